>>> rtl/core/bounded_array_list_unit_macros.svh
// assertion macros for the bounded array list unit
`ifndef BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH
`define BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define BAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define BAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/bal_pkg.sv
// shared types and constants for the bounded array list unit
`timescale 1ns / 1ps

package bal_pkg;

  // field widths
  localparam int OP_W   = 3;
  localparam int WORD_W = 64;
  localparam int POS_W  = 4;
  localparam int IDX_W  = 5;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // opcodes
  localparam op_t OP_APPEND       = 3'd0;
  localparam op_t OP_INSERT_FRONT = 3'd1;
  localparam op_t OP_READ_INDEX   = 3'd2;
  localparam op_t OP_READ_FIRST   = 3'd3;
  localparam op_t OP_READ_LAST    = 3'd4;
  localparam op_t OP_FIND         = 3'd5;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  // found index when there is no match
  localparam logic signed [IDX_W-1:0] NO_INDEX = '1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // memory write modes
  typedef logic [1:0] wr_mode_t;
  localparam wr_mode_t WR_NONE   = 2'd0;
  localparam wr_mode_t WR_APPEND = 2'd1;
  localparam wr_mode_t WR_FRONT  = 2'd2;
  localparam wr_mode_t WR_SHIFT  = 2'd3;

  // memory read address modes
  typedef logic [2:0] rd_mode_t;
  localparam rd_mode_t RD_NONE = 3'd0;
  localparam rd_mode_t RD_POS  = 3'd1;
  localparam rd_mode_t RD_ZERO = 3'd2;
  localparam rd_mode_t RD_LAST = 3'd3;
  localparam rd_mode_t RD_DEC  = 3'd4;
  localparam rd_mode_t RD_INC  = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     dispatch;
    wr_mode_t wr_mode;
    rd_mode_t rd_mode;
    logic     found_set;
    logic     finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_ok;
    logic ptr_zero;
    logic ptr_last;
    logic match;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/bal_ifs.sv
// channel interfaces for the bounded array list unit
`timescale 1ns / 1ps

// operation channel
interface bal_in_if;
  logic                           valid;
  logic                           ready;
  logic [bal_pkg::OP_W-1:0]       opcode;
  logic [bal_pkg::WORD_W-1:0]     data_word;
  logic [bal_pkg::POS_W-1:0]      position;

  modport source (output valid, opcode, data_word, position, input ready);
  modport sink (input valid, opcode, data_word, position, output ready);
endinterface

// result channel
interface bal_out_if;
  logic                           valid;
  logic                           ready;
  logic [bal_pkg::WORD_W-1:0]     read_value;
  logic signed [bal_pkg::IDX_W-1:0] found_index;
  logic [bal_pkg::ST_W-1:0]       status;
  logic [bal_pkg::CNT_W-1:0]      entry_count;

  modport source (output valid, read_value, found_index, status, entry_count, input ready);
  modport sink (input valid, read_value, found_index, status, entry_count, output ready);
endinterface

// capacity register write channel
interface bal_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bal_pkg::CAP_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/bounded_array_list_unit.sv
// top level of the bounded array list unit
//
//   channel   dir  payload                                          handshake
//   in_bus    in   opcode, data_word, position                      valid/ready
//   out_bus   out  read_value, found_index, status, entry_count     valid/ready
//   cfg_bus   in   data (list_capacity)                             valid/ready
//
// one transaction at a time; insert front and find walk the list entries one per cycle
// through the single memory read port.
// rst_n is synchronous, active low; the list comes up empty with capacity 10.
// a result waits in the output register while the next transaction is accepted;
// the list stalls before loading a new result until the old one is taken.
`timescale 1ns / 1ps

module bounded_array_list_unit #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  bal_in_if.sink    in_bus,
  bal_out_if.source out_bus,
  bal_cfg_if.sink   cfg_bus
);
  import bal_pkg::*;

`include "bounded_array_list_unit_macros.svh"

  cmd_t cmd;
  sts_t sts;

  // capacity register is always writable
  assign cfg_bus.ready = 1'b1;

  // controller
  bal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  bal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_bus.opcode),
    .in_data_word    (in_bus.data_word),
    .in_position     (in_bus.position),
    .cfg_valid       (cfg_bus.valid),
    .cfg_data        (cfg_bus.data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_read_value  (out_bus.read_value),
    .out_found_index (out_bus.found_index),
    .out_status      (out_bus.status),
    .out_entry_count (out_bus.entry_count)
  );

  // checks
  `BAL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_bus.valid && in_bus.ready, !in_bus.ready, "new transaction taken while one is in flight")
  `BAL_ASSERT_NOW(a_found_is_ok, clk, rst_n, out_bus.valid && out_bus.found_index != NO_INDEX, out_bus.status == ST_OK && out_bus.read_value == '0, "match reported with a read value or an error status")
  `BAL_ASSERT_NOW(a_error_no_value, clk, rst_n, out_bus.valid && out_bus.status != ST_OK, out_bus.read_value == '0 && out_bus.found_index == NO_INDEX, "failed operation returned data")
  `BAL_ASSERT_NOW(a_finish_no_write, clk, rst_n, cmd.finish, cmd.wr_mode == WR_NONE && cmd.rd_mode == RD_NONE, "memory access while loading a result")

endmodule

>>> rtl/core/bal_ctrl.sv
// sequencing state machine for the bounded array list unit
`timescale 1ns / 1ps

module bal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bal_pkg::sts_t sts,
  output bal_pkg::cmd_t cmd
);
  import bal_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_FRONT    = 3'd3;
  localparam logic [2:0] S_FIND     = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.dispatch  = 1'b0;
    cmd.wr_mode   = WR_NONE;
    cmd.rd_mode   = RD_NONE;
    cmd.found_set = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        state_nxt    = S_FINISH;
        unique case (sts.op)
          OP_APPEND: begin
            if (!sts.full) cmd.wr_mode = WR_APPEND;
          end
          OP_INSERT_FRONT: begin
            if (!sts.full) begin
              if (sts.empty) begin
                cmd.wr_mode = WR_FRONT;
              end else begin
                cmd.rd_mode = RD_LAST;
                state_nxt   = S_SHIFT;
              end
            end
          end
          OP_READ_INDEX: begin
            if (sts.pos_ok) cmd.rd_mode = RD_POS;
          end
          OP_READ_FIRST: begin
            if (!sts.empty) cmd.rd_mode = RD_ZERO;
          end
          OP_READ_LAST: begin
            if (!sts.empty) cmd.rd_mode = RD_LAST;
          end
          OP_FIND: begin
            if (!sts.empty) begin
              cmd.rd_mode = RD_ZERO;
              state_nxt   = S_FIND;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      // move the entry read last cycle one place back, read the one before it
      S_SHIFT: begin
        cmd.wr_mode = WR_SHIFT;
        if (sts.ptr_zero) begin
          state_nxt = S_FRONT;
        end else begin
          cmd.rd_mode = RD_DEC;
        end
      end
      S_FRONT: begin
        cmd.wr_mode = WR_FRONT;
        state_nxt   = S_FINISH;
      end
      // compare the entry read last cycle, fetch the next one
      S_FIND: begin
        if (sts.match) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_FINISH;
        end else if (sts.ptr_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_mode = RD_INC;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/bal_dp.sv
// entry memory, fill counter and result register of the bounded array list unit
`timescale 1ns / 1ps

module bal_dp #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bal_pkg::OP_W-1:0]         in_opcode,
  input  logic [bal_pkg::WORD_W-1:0]       in_data_word,
  input  logic [bal_pkg::POS_W-1:0]        in_position,
  input  logic                             cfg_valid,
  input  logic [bal_pkg::CAP_W-1:0]        cfg_data,
  input  bal_pkg::cmd_t                    cmd,
  output bal_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bal_pkg::WORD_W-1:0]       out_read_value,
  output logic signed [bal_pkg::IDX_W-1:0] out_found_index,
  output logic [bal_pkg::ST_W-1:0]         out_status,
  output logic [bal_pkg::CNT_W-1:0]        out_entry_count
);
  import bal_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int PW   = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     fill_nxt;
  logic [AW-1:0]     ptr_r;

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] word_r;
  logic [POS_W-1:0]  pos_r;

  status_t                  res_status_r;
  logic                     read_ok_r;
  logic signed [IDX_W-1:0]  found_r;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [WORD_W-1:0]        out_value_r;
  logic signed [IDX_W-1:0]  out_found_r;
  status_t                  out_status_r;
  logic [CNT_W-1:0]         out_count_r;

  logic              full;
  logic              empty;
  logic              pos_ok;
  logic [CW-1:0]     fill_m1;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              mem_re;
  logic [AW-1:0]     rd_addr;
  status_t           op_status;
  logic              op_reads;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      word_r <= in_data_word;
      pos_r  <= in_position;
    end
  end

  // list condition flags, capacity saturates at the storage depth
  assign fill_m1 = fill_r - CW'(1);
  assign empty   = (fill_r == '0);
  assign full    = (fill_r == CW'(DEPTH)) || (CMPW'(fill_r) >= CMPW'(cap_r));
  assign pos_ok  = (PW'(pos_r) < PW'(fill_r));

  // write port select
  always_comb begin
    mem_we  = 1'b1;
    wr_addr = '0;
    wr_data = word_r;
    case (cmd.wr_mode)
      WR_APPEND: wr_addr = AW'(fill_r);
      WR_FRONT:  wr_addr = '0;
      WR_SHIFT: begin
        wr_addr = ptr_r + AW'(1);
        wr_data = rdata_r;
      end
      default:   mem_we = 1'b0;
    endcase
  end

  // read port select
  always_comb begin
    mem_re  = 1'b1;
    rd_addr = '0;
    case (cmd.rd_mode)
      RD_POS:  rd_addr = AW'(pos_r);
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = AW'(fill_m1);
      RD_DEC:  rd_addr = ptr_r - AW'(1);
      RD_INC:  rd_addr = ptr_r + AW'(1);
      default: mem_re = 1'b0;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // walk pointer follows the last read address
  always_ff @(posedge clk) begin
    if (mem_re) begin
      ptr_r <= rd_addr;
    end
  end

  // fill counter
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.wr_mode == WR_APPEND || cmd.wr_mode == WR_FRONT) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // status of the operation, judged on the fill before it
  always_comb begin
    op_status = ST_OK;
    op_reads  = 1'b0;
    case (op_r) inside
      OP_APPEND, OP_INSERT_FRONT: begin
        if (full) op_status = ST_FULL;
      end
      OP_READ_INDEX: begin
        if (pos_ok) op_reads = 1'b1;
        else op_status = ST_RANGE;
      end
      OP_READ_FIRST, OP_READ_LAST: begin
        if (empty) op_status = ST_EMPTY;
        else op_reads = 1'b1;
      end
      default: op_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      res_status_r <= op_status;
      read_ok_r    <= op_reads;
    end
  end

  // search result
  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      found_r <= NO_INDEX;
    end else if (cmd.found_set) begin
      found_r <= $signed(IDX_W'(ptr_r));
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r  <= read_ok_r ? rdata_r : '0;
      out_found_r  <= found_r;
      out_status_r <= res_status_r;
      out_count_r  <= CNT_W'(fill_r);
    end
  end

  // status to the controller
  assign sts.op       = op_r;
  assign sts.full     = full;
  assign sts.empty    = empty;
  assign sts.pos_ok   = pos_ok;
  assign sts.ptr_zero = (ptr_r == '0);
  assign sts.ptr_last = (CW'(ptr_r) == fill_m1);
  assign sts.match    = (rdata_r == word_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule
